@@ design/hpdc_pkg.sv @@
// Package for the heater PID duty controller: widths, limits, codes and register indexes.
package hpdc_pkg;

    // Field and register widths.
    localparam int TEMP_W     = 15;
    localparam int TARGET_W   = 12;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 7;
    localparam int BAND_W     = 12;
    localparam int ERR_W      = 16;
    localparam int TICK_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Integral accumulator width; the accumulator saturates at all ones.
    localparam int INTEGRAL_WIDTH = 24;

    // Signed width used for temperature and error comparisons.
    localparam int CMP_W = 17;
    // Width of the derivative term (error minus last error).
    localparam int DER_W = 18;
    // Q8.8 gains times Q4 error; the duty is the sum shifted right by this.
    localparam int DUTY_SHIFT = 12;
    // Width of the P+I+D sum, wide enough for any of the three products plus carries.
    localparam int SUM_W = GAIN_W + ((INTEGRAL_WIDTH > DER_W) ? INTEGRAL_WIDTH : DER_W) + 3;

    // Toggle mode timing in control ticks.
    localparam logic [TICK_W-1:0] TOGGLE_ON_TICKS  = TICK_W'(2);
    localparam logic [TICK_W-1:0] TOGGLE_OFF_TICKS = TICK_W'(2);
    localparam logic [TICK_W-1:0] TICK_MAX         = '1;

    // Temperature limits in 1/16 degree units.
    localparam logic signed [CMP_W-1:0] LOW_LIMIT    = CMP_W'(-160);  // -10 degrees
    localparam logic signed [CMP_W-1:0] HIGH_LIMIT   = CMP_W'(3360);  // 210 degrees
    localparam logic signed [CMP_W-1:0] TOGGLE_LIMIT = CMP_W'(1920);  // 120 degrees
    localparam logic signed [CMP_W-1:0] CLEAR_LIMIT  = CMP_W'(-10);   // about -0.6 degrees

    // Largest duty percent.
    localparam logic [DUTY_W-1:0] PCT_LIMIT = DUTY_W'(100);

    // Mode reported with each result.
    typedef enum logic [2:0] {
        MODE_PID    = 3'd0,
        MODE_TOGGLE = 3'd1,
        MODE_FULL   = 3'd2,
        MODE_OFF    = 3'd3,
        MODE_FAULT  = 3'd4
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_TEMP  = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_DUTY_FLOOR   = 3'd4,
        REG_DUTY_CEILING = 3'd5,
        REG_BAND_BELOW   = 3'd6,
        REG_BAND_ABOVE   = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [TARGET_W-1:0] TARGET_RESET   = '0;
    localparam logic [GAIN_W-1:0]   GAIN_P_RESET   = GAIN_W'(1280);
    localparam logic [GAIN_W-1:0]   GAIN_I_RESET   = GAIN_W'(77);
    localparam logic [GAIN_W-1:0]   GAIN_D_RESET   = GAIN_W'(5120);
    localparam logic [DUTY_W-1:0]   FLOOR_RESET    = DUTY_W'(2);
    localparam logic [DUTY_W-1:0]   CEILING_RESET  = DUTY_W'(100);
    localparam logic [BAND_W-1:0]   BELOW_RESET    = BAND_W'(320);
    localparam logic [BAND_W-1:0]   ABOVE_RESET    = BAND_W'(16);

endpackage

@@ design/heater_pid_duty_control_unit.sv @@
// Heater PID duty controller: input register, one pass of PID and mode logic, result register.
// An accepted item is held in the input register, computed once the result register is free or
// being taken, and registered in the result register, from which the master side offers it.
// Throughput: one item per cycle unless m_tready stalls the result stream; the controller state
// (error, integral, held duty, toggle count, fault report) is read and updated for each item.
// Reset (rst_n low, asynchronous) clears the pipeline valids and the state, and loads the
// configuration registers with their default values.
module heater_pid_duty_control_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [hpdc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hpdc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hpdc_pkg::IN_DATA_W-1:0]       s_tdata,   // [14:0] temp_sample
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hpdc_pkg::OUT_DATA_W-1:0]      m_tdata    // [6:0] duty_percent,
                                                            // [7] sensor_fault,
                                                            // [8] fault_first,
                                                            // [11:9] mode_used
);
    import hpdc_pkg::*;

    // Configuration registers.
    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   gain_p_reg;
    logic [GAIN_W-1:0]   gain_i_reg;
    logic [GAIN_W-1:0]   gain_d_reg;
    logic [DUTY_W-1:0]   duty_floor_reg;
    logic [DUTY_W-1:0]   duty_ceiling_reg;
    logic [BAND_W-1:0]   band_below_reg;
    logic [BAND_W-1:0]   band_above_reg;

    // Controller state.
    logic signed [ERR_W-1:0]   last_error_reg;
    logic [INTEGRAL_WIDTH-1:0] error_sum_reg;
    logic [DUTY_W-1:0]         held_duty_reg;
    logic [TICK_W-1:0]         toggle_ticks_reg;
    logic                      fault_reported_reg;

    // Pipeline registers.
    logic                      in_valid_reg;
    logic signed [TEMP_W-1:0]  in_temp_reg;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    // Handshake and compute signals.
    logic                      out_free;
    logic                      fire;
    logic signed [CMP_W-1:0]   temp_x;
    logic signed [CMP_W-1:0]   target_x;
    logic signed [CMP_W-1:0]   below_x;
    logic signed [CMP_W-1:0]   above_x;
    logic signed [CMP_W-1:0]   err;
    logic signed [DER_W-1:0]   deriv;
    logic                      target_on;
    logic                      is_fault;
    logic                      in_band;
    logic                      in_toggle;
    logic                      err_pos;
    logic [INTEGRAL_WIDTH:0]   sum_ext;
    logic [INTEGRAL_WIDTH-1:0] isum_new;
    logic signed [GAIN_W+CMP_W:0]          prod_p;
    logic [GAIN_W+INTEGRAL_WIDTH-1:0]      prod_i;
    logic signed [GAIN_W+DER_W:0]          prod_d;
    logic signed [SUM_W-1:0]               pid_sum;
    logic [DUTY_W-1:0]         ceil_d;
    logic [DUTY_W-1:0]         floor_d;
    logic [DUTY_W-1:0]         pid_clamped;
    logic [DUTY_W-1:0]         pid_duty;
    logic [DUTY_W-1:0]         toggle_duty;
    logic [TICK_W-1:0]         ticks_base;
    logic [DUTY_W-1:0]         duty;
    logic                      first;
    mode_t                     mode;

    // Handshake: the compute stage moves when the result register is free or being taken.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= TARGET_RESET;
            gain_p_reg       <= GAIN_P_RESET;
            gain_i_reg       <= GAIN_I_RESET;
            gain_d_reg       <= GAIN_D_RESET;
            duty_floor_reg   <= FLOOR_RESET;
            duty_ceiling_reg <= CEILING_RESET;
            band_below_reg   <= BELOW_RESET;
            band_above_reg   <= ABOVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TARGET_TEMP:  target_reg       <= cfg_wdata[TARGET_W-1:0];
                REG_GAIN_P:       gain_p_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:       gain_i_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_DUTY_FLOOR:   duty_floor_reg   <= cfg_wdata[DUTY_W-1:0];
                REG_DUTY_CEILING: duty_ceiling_reg <= cfg_wdata[DUTY_W-1:0];
                REG_BAND_BELOW:   band_below_reg   <= cfg_wdata[BAND_W-1:0];
                REG_BAND_ABOVE:   band_above_reg   <= cfg_wdata[BAND_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_temp_reg <= $signed(s_tdata[TEMP_W-1:0]);
        end
    end

    // Operands extended to a common signed width.
    always_comb
    begin
        temp_x    = CMP_W'(in_temp_reg);
        target_x  = $signed(CMP_W'(target_reg));
        below_x   = $signed(CMP_W'(band_below_reg));
        above_x   = $signed(CMP_W'(band_above_reg));
        target_on = (target_reg != '0);
        err       = target_x - temp_x;
        deriv     = DER_W'(err) - DER_W'(last_error_reg);
        ceil_d    = (duty_ceiling_reg > PCT_LIMIT) ? PCT_LIMIT : duty_ceiling_reg;
        floor_d   = (duty_floor_reg > PCT_LIMIT) ? PCT_LIMIT : duty_floor_reg;
    end

    // Mode selection.
    always_comb
    begin
        is_fault  = !((temp_x > LOW_LIMIT) && (temp_x < HIGH_LIMIT));
        in_band   = (temp_x > (target_x - below_x)) && target_on;
        in_toggle = (temp_x > TOGGLE_LIMIT) && target_on;
    end

    // Conditional integration: add positive errors with saturation, clear on overshoot.
    always_comb
    begin
        err_pos = !err[CMP_W-1] && (err != '0);
        sum_ext = {1'b0, error_sum_reg} + (INTEGRAL_WIDTH+1)'(unsigned'(err));
        if (err_pos)
        begin
            isum_new = sum_ext[INTEGRAL_WIDTH] ? '1 : sum_ext[INTEGRAL_WIDTH-1:0];
        end
        else if (err <= CLEAR_LIMIT)
        begin
            isum_new = '0;
        end
        else
        begin
            isum_new = error_sum_reg;
        end
    end

    // The three gain products and their exact sum.
    always_comb
    begin
        prod_p  = $signed({1'b0, gain_p_reg}) * err;
        prod_i  = gain_i_reg * isum_new;
        prod_d  = $signed({1'b0, gain_d_reg}) * deriv;
        pid_sum = SUM_W'(prod_p) + SUM_W'(prod_d) + $signed(SUM_W'(prod_i));
    end

    // PID duty: clamp to 0..ceiling, then the floor and overshoot rules.
    always_comb
    begin
        if (pid_sum[SUM_W-1])
        begin
            pid_clamped = '0;
        end
        else if (pid_sum[SUM_W-2:DUTY_SHIFT] > (SUM_W-1-DUTY_SHIFT)'(ceil_d))
        begin
            pid_clamped = ceil_d;
        end
        else
        begin
            pid_clamped = pid_sum[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
        end

        pid_duty = pid_clamped;
        if ((pid_clamped < floor_d) || (target_x < temp_x))
        begin
            pid_duty = floor_d;
        end
        if (err < -above_x)
        begin
            pid_duty = '0;
        end
    end

    // Toggle duty: swap between the ceiling and zero once the phase has run its ticks, else hold.
    always_comb
    begin
        toggle_duty = held_duty_reg;
        ticks_base  = toggle_ticks_reg;
        if ((held_duty_reg == ceil_d) && (toggle_ticks_reg >= TOGGLE_ON_TICKS))
        begin
            toggle_duty = '0;
            ticks_base  = '0;
        end
        else if ((held_duty_reg == '0) && (toggle_ticks_reg >= TOGGLE_OFF_TICKS))
        begin
            toggle_duty = ceil_d;
            ticks_base  = '0;
        end
    end

    // Final duty, mode and fault report.
    always_comb
    begin
        first = 1'b0;
        if (is_fault)
        begin
            duty  = '0;
            mode  = MODE_FAULT;
            first = !fault_reported_reg;
        end
        else if (in_band)
        begin
            duty = pid_duty;
            mode = MODE_PID;
        end
        else if (in_toggle)
        begin
            duty = toggle_duty;
            mode = MODE_TOGGLE;
        end
        else if (target_on)
        begin
            duty = ceil_d;
            mode = MODE_FULL;
        end
        else
        begin
            duty = '0;
            mode = MODE_OFF;
        end
    end

    // Controller state update, once per computed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg     <= '0;
            error_sum_reg      <= '0;
            held_duty_reg      <= '0;
            toggle_ticks_reg   <= '0;
            fault_reported_reg <= 1'b0;
        end
        else if (fire)
        begin
            held_duty_reg <= duty;
            if (is_fault)
            begin
                fault_reported_reg <= 1'b1;
            end
            else if (in_band)
            begin
                last_error_reg <= err[ERR_W-1:0];
                error_sum_reg  <= isum_new;
            end
            else if (in_toggle)
            begin
                toggle_ticks_reg <= (ticks_base == TICK_MAX) ? ticks_base
                                                             : ticks_base + TICK_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= OUT_DATA_W'({mode, first, is_fault, duty});
        end
    end

    // A first-fault report only comes with a fault.
    a_first_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg[8] || out_data_reg[7]))
        else $error("fault_first without sensor_fault");

    // A faulty result always carries zero duty.
    a_fault_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[7]) |-> (out_data_reg[DUTY_W-1:0] == '0))
        else $error("nonzero duty on a fault result");

    // The duty never exceeds 100 percent.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[DUTY_W-1:0] <= PCT_LIMIT))
        else $error("duty above 100 percent");

    // The fault report flag never clears once set.
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reported_reg |=> fault_reported_reg)
        else $error("fault report flag cleared");

    // Controller state only moves when an item is computed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(error_sum_reg) && $stable(toggle_ticks_reg)
                   && $stable(held_duty_reg) && $stable(last_error_reg)))
        else $error("controller state changed without an item");

endmodule

@@ test/tb_heater_pid_duty_control_unit.sv @@
// Self-checking testbench for the heater PID duty controller with directed and random samples.
module tb_heater_pid_duty_control_unit;

    import hpdc_pkg::*;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     HOLD_CYCLES   = 120;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     FAULT_BIT     = DUTY_W;
    localparam int     FIRST_BIT     = DUTY_W + 1;
    localparam int     MODE_LSB      = DUTY_W + 2;
    localparam int     TEMP_MIN      = -(1 << (TEMP_W - 1));
    localparam int     TEMP_MAX      = (1 << (TEMP_W - 1)) - 1;
    localparam int     WALK_LOW      = int'(LOW_LIMIT) + 1;
    localparam int     WALK_HIGH     = int'(HIGH_LIMIT) - 1;
    localparam longint INTEGRAL_MAX  = (longint'(1) << INTEGRAL_WIDTH) - 1;

    // Register settings as the controller holds them.
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
        logic [DUTY_W-1:0]   floor_pct;
        logic [DUTY_W-1:0]   ceil_pct;
        logic [BAND_W-1:0]   below;
        logic [BAND_W-1:0]   above;
    } heater_cfg_t;

    // One predicted duty result.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              fault;
        logic              first;
        mode_t             mode;
    } duty_result_t;

    // Ways the result receiver paces its ready signal.
    typedef enum logic [1:0] {
        SINK_OPEN   = 2'd0,
        SINK_COIN   = 2'd1,
        SINK_SPARSE = 2'd2,
        SINK_BURST  = 2'd3
    } sink_style_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state and its copy of the registers.
    heater_cfg_t           cur_cfg;
    logic signed [ERR_W-1:0] prev_err;
    logic [INTEGRAL_WIDTH-1:0] integral_acc;
    logic [DUTY_W-1:0]     held_pct;
    logic [TICK_W-1:0]     toggle_run;
    logic                  fault_flagged;

    duty_result_t          expected_duty[$];
    duty_result_t          head;
    int                    mismatch_count = 0;
    int                    results_seen   = 0;
    int                    cycle_count    = 0;
    int                    walk_temp      = 0;

    // Receiver pacing and the long hold-off request.
    int                    hold_token = 0;
    int                    hold_seen  = 0;
    int                    hold_left  = 0;
    sink_style_t           sink_style = SINK_OPEN;
    int                    sink_left  = 0;

    heater_pid_duty_control_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a period of 10 time units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog that ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_heater_pid_duty_control_unit failed");
            $finish;
        end
    end

    // The receiver stalls on its own pattern, or holds off for a long stretch on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (sink_left == 0)
            begin
                sink_style <= sink_style_t'($urandom_range(0, 3));
                sink_left  <= $urandom_range(16, 80);
            end
            else
                sink_left <= sink_left - 1;
            case (sink_style)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_COIN:   m_tready <= $urandom_range(0, 1);
                SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (sink_left % 8) < 5;
            endcase
        end
    end

    // Each accepted result is compared with the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_duty.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Result %0d (%h) arrived with no sample outstanding.",
                             results_seen, m_tdata);
            end
            else
            begin
                head = expected_duty.pop_front();
                if (m_tdata[DUTY_W-1:0] !== head.duty || m_tdata[FAULT_BIT] !== head.fault
                    || m_tdata[FIRST_BIT] !== head.first
                    || m_tdata[MODE_LSB +: $bits(mode_t)] !== head.mode)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result %0d: expected duty %0d fault %0b first %0b mode %0d, %s",
                                 results_seen, head.duty, head.fault, head.first, head.mode,
                                 $sformatf("got duty %0d fault %0b first %0b mode %0d",
                                           m_tdata[DUTY_W-1:0], m_tdata[FAULT_BIT],
                                           m_tdata[FIRST_BIT],
                                           m_tdata[MODE_LSB +: $bits(mode_t)]));
                end
            end
        end
    end

    // Computes the duty result of one sample and advances the controller state.
    function automatic duty_result_t predict_tick(input logic [TEMP_W-1:0] raw);
        duty_result_t r;
        int           t;
        int           tgt;
        int           err;
        int           ceil_d;
        int           floor_d;
        int           duty;
        longint       integ;
        longint       sum;
        longint       quot;
        t       = int'($signed(raw));
        tgt     = int'(cur_cfg.target);
        ceil_d  = (cur_cfg.ceil_pct > PCT_LIMIT) ? int'(PCT_LIMIT) : int'(cur_cfg.ceil_pct);
        floor_d = (cur_cfg.floor_pct > PCT_LIMIT) ? int'(PCT_LIMIT) : int'(cur_cfg.floor_pct);
        r.fault = 1'b0;
        r.first = 1'b0;
        if (t <= int'(LOW_LIMIT) || t >= int'(HIGH_LIMIT))
        begin
            // Sensor fault: duty off, the report fires once after reset.
            r.fault = 1'b1;
            duty    = 0;
            r.mode  = MODE_FAULT;
            if (!fault_flagged)
            begin
                r.first       = 1'b1;
                fault_flagged = 1'b1;
            end
        end
        else if (t > tgt - int'(cur_cfg.below) && tgt > 0)
        begin
            // Regulation: the integral grows only on a positive error and clears on overshoot.
            err   = tgt - t;
            integ = longint'(integral_acc);
            if (err > 0)
            begin
                integ = integ + err;
                if (integ > INTEGRAL_MAX)
                    integ = INTEGRAL_MAX;
            end
            else if (err <= int'(CLEAR_LIMIT))
                integ = 0;
            integral_acc = integ[INTEGRAL_WIDTH-1:0];
            sum = longint'(cur_cfg.kp) * err + longint'(cur_cfg.ki) * integ
                + longint'(cur_cfg.kd) * (err - int'(prev_err));
            prev_err = ERR_W'(err);
            if (sum < 0)
                duty = 0;
            else
            begin
                quot = sum >>> DUTY_SHIFT;
                duty = (quot > ceil_d) ? ceil_d : int'(quot);
            end
            if (duty < floor_d || tgt < t)
                duty = floor_d;
            if (err < -int'(cur_cfg.above))
                duty = 0;
            r.mode = MODE_PID;
        end
        else if (t > int'(TOGGLE_LIMIT) && tgt > 0)
        begin
            // Hot but below the band: on and off in turns, a middle duty is kept.
            duty = int'(held_pct);
            if (duty == ceil_d && toggle_run >= TOGGLE_ON_TICKS)
            begin
                duty       = 0;
                toggle_run = '0;
            end
            else if (duty == 0 && toggle_run >= TOGGLE_OFF_TICKS)
            begin
                duty       = ceil_d;
                toggle_run = '0;
            end
            if (toggle_run != TICK_MAX)
                toggle_run = toggle_run + 1'b1;
            r.mode = MODE_TOGGLE;
        end
        else if (tgt > 0)
        begin
            duty   = ceil_d;
            r.mode = MODE_FULL;
        end
        else
        begin
            duty   = 0;
            r.mode = MODE_OFF;
        end
        held_pct = DUTY_W'(duty);
        r.duty   = held_pct;
        return r;
    endfunction

    // Picks the next sample: mostly a slow walk around the target, sometimes a jump or a limit.
    function automatic int next_temp();
        int tgt;
        int pick;
        tgt  = int'(cur_cfg.target);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        if (pick == 1)
        begin
            case ($urandom_range(0, 13))
                0:       return TEMP_MIN;
                1:       return TEMP_MAX;
                2:       return int'(LOW_LIMIT);
                3:       return WALK_LOW;
                4:       return WALK_HIGH;
                5:       return int'(HIGH_LIMIT);
                6:       return int'(TOGGLE_LIMIT);
                7:       return int'(TOGGLE_LIMIT) + 1;
                8:       return tgt - int'(cur_cfg.below);
                9:       return tgt - int'(cur_cfg.below) + 1;
                10:      return tgt + int'(cur_cfg.above);
                11:      return tgt + int'(cur_cfg.above) + 1;
                12:      return tgt - int'(CLEAR_LIMIT);
                default: return tgt - int'(CLEAR_LIMIT) - 1;
            endcase
        end
        if (pick == 2)
            walk_temp = int'($urandom_range(int'(TOGGLE_LIMIT) + 1, WALK_HIGH));
        else if (pick == 3)
            walk_temp = tgt - int'(cur_cfg.below) - int'($urandom_range(0, 200));
        else if (walk_temp < tgt)
            walk_temp = walk_temp + int'($urandom_range(0, 28)) - 8;
        else
            walk_temp = walk_temp + int'($urandom_range(0, 18)) - 12;
        if (walk_temp < WALK_LOW)
            walk_temp = WALK_LOW;
        if (walk_temp > WALK_HIGH)
            walk_temp = WALK_HIGH;
        return walk_temp;
    endfunction

    // Random register settings, mostly ones that keep the controller regulating.
    function automatic heater_cfg_t random_settings();
        heater_cfg_t c;
        c.target    = ($urandom_range(0, 7) == 0) ? '0 : TARGET_W'($urandom_range(100, 3400));
        c.kp        = ($urandom_range(0, 1) != 0) ? GAIN_W'($urandom_range(0, 8000))
                                                  : GAIN_W'($urandom);
        c.ki        = ($urandom_range(0, 1) != 0) ? GAIN_W'($urandom_range(0, 400))
                                                  : GAIN_W'($urandom);
        c.kd        = ($urandom_range(0, 1) != 0) ? GAIN_W'($urandom_range(0, 8000))
                                                  : GAIN_W'($urandom);
        c.floor_pct = DUTY_W'($urandom_range(0, 20));
        c.ceil_pct  = DUTY_W'($urandom_range(30, 100));
        c.below     = BAND_W'($urandom_range(0, 1200));
        c.above     = BAND_W'($urandom_range(0, 200));
        return c;
    endfunction

    // Offers one sample, waits for its acceptance and records the predicted result.
    task automatic send_temp(input int temp);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(temp[TEMP_W-1:0]);
        do
            @(posedge clk);
        while (!s_tready);
        expected_duty.push_back(predict_tick(temp[TEMP_W-1:0]));
    endtask

    // Leaves the input idle for a number of cycles.
    task automatic pause_input(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= IN_DATA_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_duty.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all registers once the controller is idle.
    task automatic apply_settings(input heater_cfg_t c);
        logic [CFG_DATA_W-1:0] value;
        wait_results_done();
        for (int i = 0; i <= int'(REG_BAND_ABOVE); i++)
        begin
            case (cfg_reg_t'(i))
                REG_TARGET_TEMP:  value = CFG_DATA_W'(c.target);
                REG_GAIN_P:       value = CFG_DATA_W'(c.kp);
                REG_GAIN_I:       value = CFG_DATA_W'(c.ki);
                REG_GAIN_D:       value = CFG_DATA_W'(c.kd);
                REG_DUTY_FLOOR:   value = CFG_DATA_W'(c.floor_pct);
                REG_DUTY_CEILING: value = CFG_DATA_W'(c.ceil_pct);
                REG_BAND_BELOW:   value = CFG_DATA_W'(c.below);
                default:          value = CFG_DATA_W'(c.above);
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= cfg_reg_t'(i);
            cfg_wdata <= value;
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // Sends random-walk samples in bursts, with or without idle gaps between them.
    task automatic run_walk(input int count, input bit with_gaps);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                send_temp(next_temp());
                burst--;
                left--;
            end
            if (with_gaps && $urandom_range(0, 2) != 0)
                pause_input($urandom_range(1, 7));
        end
    endtask

    // With no target the heater is off; samples on and beyond both limits are faults.
    task automatic test_off_and_faults();
        send_temp(0);
        send_temp(int'(LOW_LIMIT));
        send_temp(int'(HIGH_LIMIT));
        send_temp(TEMP_MIN);
        send_temp(TEMP_MAX);
        send_temp(WALK_LOW);
        send_temp(WALK_HIGH);
    endtask

    // Band edge, integration, the clear threshold, the floor and the overshoot cutoff.
    task automatic test_regulation_band();
        heater_cfg_t c;
        c        = cur_cfg;
        c.target = TARGET_W'(1600);
        apply_settings(c);
        send_temp(1280);
        send_temp(1281);
        send_temp(1590);
        send_temp(1600);
        send_temp(1609);
        send_temp(1610);
        send_temp(1617);
        send_temp(1595);
    endtask

    // Full power below the toggle limit, then the on and off turns above it.
    task automatic test_toggle_and_full();
        heater_cfg_t c;
        c        = cur_cfg;
        c.target = TARGET_W'(4000);
        c.below  = BAND_W'(1500);
        apply_settings(c);
        send_temp(1000);
        repeat (5) send_temp(2000);
        send_temp(int'(TOGGLE_LIMIT));
        send_temp(int'(TOGGLE_LIMIT) + 1);
    endtask

    // A floor above the ceiling, and duty registers above 100.
    task automatic test_duty_limits();
        heater_cfg_t c;
        c           = cur_cfg;
        c.target    = TARGET_W'(1600);
        c.below     = BAND_W'(320);
        c.floor_pct = DUTY_W'(120);
        c.ceil_pct  = DUTY_W'(50);
        apply_settings(c);
        send_temp(1281);
        send_temp(1605);
        c.floor_pct = '0;
        c.ceil_pct  = DUTY_W'(110);
        apply_settings(c);
        send_temp(1281);
        send_temp(1620);
    endtask

    // The receiver holds off for a long time while samples keep coming.
    task automatic test_backpressure();
        apply_settings(random_settings());
        walk_temp  = int'(cur_cfg.target) - int'(cur_cfg.below);
        hold_token <= hold_token + 1;
        repeat (40) send_temp(next_temp());
        wait_results_done();
    endtask

    // A large steady error winds the integral up tick by tick.
    task automatic test_integral_windup();
        heater_cfg_t c;
        c.target    = '1;
        c.kp        = '0;
        c.ki        = GAIN_W'(1);
        c.kd        = '0;
        c.floor_pct = '0;
        c.ceil_pct  = PCT_LIMIT;
        c.below     = '1;
        c.above     = '1;
        apply_settings(c);
        repeat (30) send_temp(1);
        send_temp(WALK_HIGH);
    endtask

    // A middle duty held in toggle mode lets the tick counter reach its limit.
    task automatic test_toggle_counter_saturation();
        heater_cfg_t c;
        c.target    = TARGET_W'(4000);
        c.kp        = '0;
        c.ki        = '0;
        c.kd        = '0;
        c.floor_pct = DUTY_W'(37);
        c.ceil_pct  = DUTY_W'(90);
        c.below     = BAND_W'(1500);
        c.above     = BAND_W'(16);
        apply_settings(c);
        send_temp(2600);
        repeat (260)
        begin
            send_temp(2200);
            if ($urandom_range(0, 15) == 0)
                pause_input($urandom_range(1, 5));
        end
        send_temp(1000);
        repeat (5) send_temp(2200);
    endtask

    // Several register settings, the extremes first, each with random-walk samples.
    task automatic test_random_settings();
        heater_cfg_t c;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                c.target    = TARGET_W'(3000);
                c.kp        = '1;
                c.ki        = '1;
                c.kd        = '1;
                c.floor_pct = '0;
                c.ceil_pct  = PCT_LIMIT;
                c.below     = '1;
                c.above     = '1;
            end
            else if (phase == 1)
            begin
                c.target    = '1;
                c.kp        = '0;
                c.ki        = '0;
                c.kd        = '0;
                c.floor_pct = PCT_LIMIT;
                c.ceil_pct  = '0;
                c.below     = '0;
                c.above     = '0;
            end
            else
                c = random_settings();
            apply_settings(c);
            walk_temp = int'(cur_cfg.target) - int'(cur_cfg.below)
                      - int'($urandom_range(0, 200));
            run_walk(22, phase != 2);
        end
    endtask

    // Reset once, run every test in turn, then report.
    initial
    begin
        cur_cfg.target    = TARGET_RESET;
        cur_cfg.kp        = GAIN_P_RESET;
        cur_cfg.ki        = GAIN_I_RESET;
        cur_cfg.kd        = GAIN_D_RESET;
        cur_cfg.floor_pct = FLOOR_RESET;
        cur_cfg.ceil_pct  = CEILING_RESET;
        cur_cfg.below     = BELOW_RESET;
        cur_cfg.above     = ABOVE_RESET;
        prev_err          = '0;
        integral_acc      = '0;
        held_pct          = '0;
        toggle_run        = '0;
        fault_flagged     = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_off_and_faults();
        test_regulation_band();
        test_toggle_and_full();
        test_duty_limits();
        test_backpressure();
        test_integral_windup();
        test_toggle_counter_saturation();
        test_random_settings();

        wait_results_done();
        if (mismatch_count == 0)
            $display("tb_heater_pid_duty_control_unit passed");
        else
            $display("tb_heater_pid_duty_control_unit failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/hpdc_pkg.sv
design/heater_pid_duty_control_unit.sv
test/tb_heater_pid_duty_control_unit.sv
